/* sv/swfd_pkg.sv */
// swfd_pkg: types, codes and the FCS-16 byte update for the sync-word frame deframer.
// Standalone; imported by swfd_core and sync_word_frame_deframer.
package swfd_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       chunk_end;
	} swfd_in_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  out_byte;
		logic [7:0]  command;
		logic [15:0] body_length;
		logic        fits_capacity;
		logic        need_more;
	} swfd_out_t;

	typedef logic [2:0] swfd_status_t;

	localparam swfd_status_t ST_HUNT     = 3'd0;
	localparam swfd_status_t ST_HEADER   = 3'd1;
	localparam swfd_status_t ST_BODY     = 3'd2;
	localparam swfd_status_t ST_GOOD     = 3'd3;
	localparam swfd_status_t ST_BAD_FCS  = 3'd4;
	localparam swfd_status_t ST_TOO_LONG = 3'd5;

	// config register indexes
	localparam logic REG_MAX_BODY_LENGTH = 1'b0;
	localparam logic REG_OUTPUT_CAPACITY = 1'b1;

	localparam logic [15:0] MAX_BODY_RESET = 16'd1015;
	localparam logic [15:0] CAPACITY_RESET = 16'd1024;

	localparam logic [23:0] SYNC_LAST3     = 24'h55AA55;
	localparam logic [7:0]  SYNC_TAIL      = 8'hAA;
	localparam logic [15:0] FCS_INIT       = 16'hFFFF;
	localparam logic [15:0] FCS_POLY       = 16'h8408;
	localparam logic [15:0] FCS_XOROUT     = 16'hFFFF;
	localparam logic [16:0] FRAME_OVERHEAD = 17'd9;

	// reflected CRC-16, one byte, bit at a time
	function automatic logic [15:0] fcs16_byte(input logic [15:0] fcs, input logic [7:0] b);
		logic [15:0] c;
		c = fcs ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ FCS_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	// check value after the four sync bytes, settled at elaboration
	localparam logic [15:0] FCS_AFTER_SYNC =
		fcs16_byte(fcs16_byte(fcs16_byte(fcs16_byte(FCS_INIT, 8'h55), 8'hAA), 8'h55), 8'hAA);

endpackage

/* sv/swfd_core.sv */
// swfd_core: frame state machine, FCS accumulator and per-byte result logic.
// Depends on swfd_pkg.
module swfd_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step_en,
	input  swfd_pkg::swfd_in_t  item,
	input  logic [15:0]         max_body_length,
	input  logic [15:0]         output_capacity,
	output swfd_pkg::swfd_out_t result
);
	import swfd_pkg::*;

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_CMD,
		PH_LEN_HI,
		PH_LEN_LO,
		PH_BODY,
		PH_CHK_LO,
		PH_CHK_HI
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [23:0] recent_q, recent_d;
	logic [7:0]  cmd_q, cmd_d;
	logic [15:0] len_q, len_d;
	logic [15:0] cnt_q, cnt_d;
	logic [15:0] fcs_q, fcs_d;
	logic [7:0]  chk_lo_q, chk_lo_d;

	logic [15:0] fcs_upd;
	logic [15:0] len_full;
	logic [15:0] cnt_dec;
	logic [16:0] frame_len;

	assign fcs_upd   = fcs16_byte(fcs_q, item.data_byte);
	assign len_full  = {len_q[15:8], item.data_byte};
	assign cnt_dec   = cnt_q - 16'd1;
	assign frame_len = {1'b0, len_q} + FRAME_OVERHEAD;

	always_comb begin
		phase_d  = phase_q;
		recent_d = recent_q;
		cmd_d    = cmd_q;
		len_d    = len_q;
		cnt_d    = cnt_q;
		fcs_d    = fcs_q;
		chk_lo_d = chk_lo_q;
		result   = '0;
		case (phase_q)
			PH_CMD: begin
				cmd_d         = item.data_byte;
				fcs_d         = fcs_upd;
				phase_d       = PH_LEN_HI;
				result.status = ST_HEADER;
			end
			PH_LEN_HI: begin
				len_d         = {item.data_byte, 8'h00};
				fcs_d         = fcs_upd;
				phase_d       = PH_LEN_LO;
				result.status = ST_HEADER;
			end
			PH_LEN_LO: begin
				len_d = len_full;
				fcs_d = fcs_upd;
				if (len_full > max_body_length) begin
					result.status = ST_TOO_LONG;
					phase_d       = PH_HUNT;
					recent_d      = '0;
				end else begin
					result.status = ST_HEADER;
					cnt_d         = len_full;
					phase_d       = (len_full == '0) ? PH_CHK_LO : PH_BODY;
				end
			end
			PH_BODY: begin
				fcs_d           = fcs_upd;
				result.out_byte = item.data_byte;
				result.status   = ST_BODY;
				cnt_d           = cnt_dec;
				if (cnt_dec == '0) begin
					phase_d = PH_CHK_LO;
				end
			end
			PH_CHK_LO: begin
				chk_lo_d      = item.data_byte;
				result.status = ST_HEADER;
				phase_d       = PH_CHK_HI;
			end
			PH_CHK_HI: begin
				if ({item.data_byte, chk_lo_q} == (fcs_q ^ FCS_XOROUT)) begin
					result.status        = ST_GOOD;
					result.fits_capacity = (frame_len <= {1'b0, output_capacity});
				end else begin
					result.status = ST_BAD_FCS;
				end
				phase_d  = PH_HUNT;
				recent_d = '0;
			end
			default: begin
				if (recent_q == SYNC_LAST3 && item.data_byte == SYNC_TAIL) begin
					fcs_d         = FCS_AFTER_SYNC;
					recent_d      = '0;
					cmd_d         = '0;
					len_d         = '0;
					cnt_d         = '0;
					chk_lo_d      = '0;
					phase_d       = PH_CMD;
					result.status = ST_HEADER;
				end else begin
					recent_d      = {recent_q[15:0], item.data_byte};
					phase_d       = PH_HUNT;
					result.status = ST_HUNT;
				end
			end
		endcase
		result.command     = cmd_d;
		result.body_length = len_d;
		result.need_more   = item.chunk_end && (phase_d != PH_HUNT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			recent_q <= '0;
			cmd_q    <= '0;
			len_q    <= '0;
			cnt_q    <= '0;
			fcs_q    <= FCS_INIT;
			chk_lo_q <= '0;
		end else if (step_en) begin
			phase_q  <= phase_d;
			recent_q <= recent_d;
			cmd_q    <= cmd_d;
			len_q    <= len_d;
			cnt_q    <= cnt_d;
			fcs_q    <= fcs_d;
			chk_lo_q <= chk_lo_d;
		end
	end

endmodule

/* sv/sync_word_frame_deframer.sv */
// sync_word_frame_deframer: top level; input register, config registers, result register.
// Depends on swfd_pkg and swfd_core.
//
//  Channel  Direction  Handshake              Payload
//  in       sink       in_valid / in_stall    in_data  (swfd_in_t: data_byte, chunk_end)
//  out      source     out_valid / out_stall  out_data (swfd_out_t, one result per byte)
//  cfg      sink       cfg_we                 cfg_index, cfg_data (16 bit)
//
// One byte per cycle sustained while out is not stalled; a byte passes the input
// register, then the state step and FCS update into the result register.
// The FCS byte update plus the state step form the only logic between registers.
// Reset clears the pipeline valids and frame state; config returns to 1015 / 1024.
// A stall on out holds the result register; in keeps accepting while its own
// register is empty, so a stall reaches in_stall only with both stages full.
module sync_word_frame_deframer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  swfd_pkg::swfd_in_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output swfd_pkg::swfd_out_t out_data,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [15:0]         cfg_data
);
	import swfd_pkg::*;

	logic        valid_s1;
	swfd_in_t    data_s1;
	logic        out_valid_q;
	swfd_out_t   out_data_q;
	logic [15:0] max_body_q;
	logic [15:0] capacity_q;

	logic      advance;   // result register free to load
	logic      step;      // stage-1 byte moves to output, state commits
	swfd_out_t result;

	assign advance  = !out_valid_q || !out_stall;
	assign step     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	swfd_core u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.step_en         (step),
		.item            (data_s1),
		.max_body_length (max_body_q),
		.output_capacity (capacity_q),
		.result          (result)
	);

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_body_q <= MAX_BODY_RESET;
			capacity_q <= CAPACITY_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAX_BODY_LENGTH: max_body_q <= cfg_data;
				REG_OUTPUT_CAPACITY: capacity_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1 <= in_data;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
